@@ design/sfcc_pkg.sv @@
`timescale 1ns / 1ps

package sfcc_pkg;

  // CRC-8 parameters of the sensor readout
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Scale factors (full scale 65535 maps to these values)
  localparam logic [14:0] SCALE_TEMP_C = 15'd17500;
  localparam logic [14:0] SCALE_TEMP_F = 15'd31500;
  localparam logic [14:0] SCALE_HUM    = 15'd10000;
  localparam logic [15:0] OFFSET_C     = 16'd4500;
  localparam logic [15:0] OFFSET_F     = 16'd4900;

  // Product widths: 65535 * 31500 fits 31 bits
  localparam int unsigned ProdW = 31;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_WORDS_PER_FRAME = 1'b0,
    CFG_TEMP_UNIT       = 1'b1
  } cfg_idx_e;

  // Frame status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_FIRST = 2'd1,
    STATUS_BAD_SECOND = 2'd2
  } status_e;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_item_t;

  // Result transaction payload
  typedef struct packed {
    logic [1:0]         frame_status;
    logic [15:0]        first_word;
    logic [15:0]        second_word;
    logic signed [15:0] temperature_centi;
    logic [13:0]        humidity_centi;
  } result_item_t;

  // Completed frame handed from the parser to the scaler
  typedef struct packed {
    status_e     status;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic        single;
    logic        fahrenheit;
  } frame_t;

  // One byte step of the MSB-first CRC-8
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // round(prod / 65535): add half, then divide by 65535 as x/65536 plus one
  // correction step, since x mod 65535 = (x mod 65536) + (x / 65536) stays
  // below twice the divisor
  function automatic logic [15:0] div65535_round(input logic [ProdW-1:0] prod);
    logic [31:0] x;
    logic [15:0] q0;
    logic [16:0] r;
    x  = {1'b0, prod} + 32'd32767;
    q0 = x[31:16];
    r  = {1'b0, x[15:0]} + {1'b0, q0};
    return (r >= 17'd65535) ? q0 + 16'd1 : q0;
  endfunction

endpackage

@@ design/sfcc_if.sv @@
`timescale 1ns / 1ps

interface sfcc_byte_if;
  import sfcc_pkg::*;
  logic       valid;
  logic       ready;
  byte_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfcc_result_if;
  import sfcc_pkg::*;
  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/sfcc_front.sv @@
`timescale 1ns / 1ps

module sfcc_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [1:0]       cfg_data_i,
  sfcc_byte_if.sink        byte_i,
  output logic             push_valid_o,
  output sfcc_pkg::frame_t push_data_o,
  input  logic             push_ready_i
);
  import sfcc_pkg::*;

  // Byte positions inside a frame
  localparam logic [2:0] POS_MSB1 = 3'd0;
  localparam logic [2:0] POS_LSB1 = 3'd1;
  localparam logic [2:0] POS_CRC1 = 3'd2;
  localparam logic [2:0] POS_MSB2 = 3'd3;
  localparam logic [2:0] POS_LSB2 = 3'd4;
  localparam logic [2:0] POS_CRC2 = 3'd5;

  logic [1:0]  words_q, words_d;
  logic        unit_q, unit_d;
  logic [2:0]  pos_q, pos_d, pos_e;
  logic [7:0]  crc_q, crc_d, crc_e, crc_b;
  logic        bad_q, bad_d, bad_e, crc_mismatch;
  logic [15:0] w1_q, w1_d;
  logic [7:0]  high_q, high_d, low_q, low_d;
  logic        fire, single;
  logic [7:0]  b;

  assign byte_i.ready = push_ready_i;
  assign fire         = byte_i.valid && push_ready_i;
  assign b            = byte_i.data.rx_byte;
  assign single       = (words_q == 2'd1);

  // Apply configuration writes
  always_comb begin
    words_d = words_q;
    unit_d  = unit_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WORDS_PER_FRAME: words_d = cfg_data_i;
        CFG_TEMP_UNIT:       unit_d  = cfg_data_i[0];
        default:             ;
      endcase
    end
  end

  // Restart the frame on a start mark before the byte is parsed
  always_comb begin
    pos_e        = byte_i.data.frame_start ? POS_MSB1 : pos_q;
    crc_e        = byte_i.data.frame_start ? CRC_INIT : crc_q;
    bad_e        = byte_i.data.frame_start ? 1'b0 : bad_q;
    crc_b        = crc8_update(crc_e, b);
    crc_mismatch = (crc_e != b);
  end

  // Parse one byte and hand a finished frame to the queue
  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    bad_d        = bad_q;
    w1_d         = w1_q;
    high_d       = high_q;
    low_d        = low_q;
    push_valid_o = 1'b0;
    push_data_o.status      = STATUS_OK;
    push_data_o.first_word  = w1_q;
    push_data_o.second_word = {high_q, low_q};
    push_data_o.single      = 1'b0;
    push_data_o.fahrenheit  = unit_q;
    if (fire) begin
      case (pos_e) inside
        POS_MSB1, POS_MSB2: begin
          high_d = b;
          crc_d  = crc_b;
          bad_d  = bad_e;
          pos_d  = pos_e + 3'd1;
        end
        POS_LSB1: begin
          w1_d  = {high_q, b};
          crc_d = crc_b;
          bad_d = bad_e;
          pos_d = POS_CRC1;
        end
        POS_CRC1: begin
          crc_d = CRC_INIT;
          if (single) begin
            push_valid_o            = 1'b1;
            push_data_o.status      = crc_mismatch ? STATUS_BAD_FIRST : STATUS_OK;
            push_data_o.second_word = 16'd0;
            push_data_o.single      = 1'b1;
            pos_d                   = POS_MSB1;
            bad_d                   = 1'b0;
          end else begin
            pos_d = POS_MSB2;
            bad_d = crc_mismatch;
          end
        end
        POS_LSB2: begin
          low_d = b;
          crc_d = crc_b;
          bad_d = bad_e;
          pos_d = POS_CRC2;
        end
        POS_CRC2: begin
          push_valid_o = 1'b1;
          if (bad_e) begin
            push_data_o.status = STATUS_BAD_FIRST;
          end else if (crc_mismatch) begin
            push_data_o.status = STATUS_BAD_SECOND;
          end else begin
            push_data_o.status = STATUS_OK;
          end
          pos_d = POS_MSB1;
          crc_d = CRC_INIT;
          bad_d = 1'b0;
        end
        default: begin
          pos_d = POS_MSB1;
          crc_d = CRC_INIT;
          bad_d = 1'b0;
        end
      endcase
    end
  end

  // Hold control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= 2'd2;
      unit_q  <= 1'b0;
      pos_q   <= POS_MSB1;
      crc_q   <= CRC_INIT;
      bad_q   <= 1'b0;
    end else begin
      words_q <= words_d;
      unit_q  <= unit_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
      bad_q   <= bad_d;
    end
  end

  // Hold the received word bytes
  always_ff @(posedge clk_i) begin
    w1_q   <= w1_d;
    high_q <= high_d;
    low_q  <= low_d;
  end

endmodule

@@ design/sfcc_queue.sv @@
`timescale 1ns / 1ps

module sfcc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  sfcc_pkg::frame_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output sfcc_pkg::frame_t pop_data_o,
  input  logic             pop_ready_i
);
  import sfcc_pkg::*;

  frame_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed frame
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ design/sfcc_back.sv @@
`timescale 1ns / 1ps

module sfcc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  input  sfcc_pkg::frame_t pop_data_i,
  output logic             pop_ready_o,
  sfcc_result_if.source    result_o
);
  import sfcc_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  frame_t           s1_frame_q;
  logic [ProdW-1:0] s1_temp_prod_q;
  logic [ProdW-1:0] s1_hum_prod_q;
  logic             out_valid_q, out_valid_d;
  result_item_t     out_q, out_d;
  logic             s1_ready, out_load;
  logic [14:0]      temp_scale;
  logic [15:0]      hum_src;
  logic [15:0]      temp_q16, hum_q16, temp_off;

  assign out_load    = !out_valid_q || result_o.ready;
  assign s1_ready    = !s1_valid_q || out_load;
  assign pop_ready_o = s1_ready;

  // Stage 1: multiply raw words by the unit scale
  assign temp_scale = pop_data_i.fahrenheit ? SCALE_TEMP_F : SCALE_TEMP_C;
  assign hum_src    = pop_data_i.single ? pop_data_i.first_word : pop_data_i.second_word;
  assign s1_valid_d = s1_ready ? pop_valid_i : s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (s1_ready && pop_valid_i) begin
      s1_frame_q     <= pop_data_i;
      s1_temp_prod_q <= ProdW'({15'd0, pop_data_i.first_word} * {16'd0, temp_scale});
      s1_hum_prod_q  <= ProdW'({15'd0, hum_src} * {16'd0, SCALE_HUM});
    end
  end

  // Stage 2: divide by full scale with rounding, apply the offset
  always_comb begin
    temp_q16 = div65535_round(s1_temp_prod_q);
    hum_q16  = div65535_round(s1_hum_prod_q);
    temp_off = s1_frame_q.fahrenheit ? OFFSET_F : OFFSET_C;
    out_d.frame_status      = s1_frame_q.status;
    out_d.first_word        = s1_frame_q.first_word;
    out_d.second_word       = s1_frame_q.second_word;
    out_d.temperature_centi = $signed(temp_q16 - temp_off);
    out_d.humidity_centi    = hum_q16[13:0];
    out_valid_d             = out_load ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

endmodule

@@ design/sensor_frame_crc_check_and_scale_core.sv @@
`timescale 1ns / 1ps

// Sensor frame checker and scaler. Takes one readout byte per cycle on
// byte_i (MSB, LSB, CRC-8 per word, one or two words per frame) and delivers
// one result transaction on result_o per completed frame: status, raw words,
// temperature and humidity in hundredths. A byte is taken every cycle while
// the two-frame queue between the byte parser and the scaler has room; the
// scaler is a two-stage pipeline (multiply, then divide-by-65535 and offset)
// ending in the output register; stalls on result_o back up only through
// that queue. Configuration (words_per_frame index 0, temp_unit index 1)
// must be written by the user through cfg_we_i only while no frame is in
// flight; the block itself does not enforce this.
module sensor_frame_crc_check_and_scale_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [1:0] cfg_data_i,
  sfcc_byte_if.sink     byte_i,
  sfcc_result_if.source result_o
);
  import sfcc_pkg::*;

  logic   push_valid, push_ready, pop_valid, pop_ready;
  frame_t push_data, pop_data;

  sfcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .byte_i       (byte_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready)
  );

  sfcc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  sfcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .result_o    (result_o)
  );

endmodule
